// ===== rtl/pse_pkg.sv =====
// shared types for the positional stack engine
`timescale 1ns / 1ps

package pse_pkg;

  // operation codes carried in the input item
  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_INSERT_AT = 3'd1,
    OP_PEEK      = 3'd2,
    OP_READ_AT   = 3'd3,
    OP_POP       = 3'd4,
    OP_REMOVE_AT = 3'd5,
    OP_REVERSE   = 3'd6
  } op_e;

  // status codes carried in the result item
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // per-cell update command
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LOWER = 2'd1,
    CELL_FROM_UPPER = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_cmd_e;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned PosWidth    = 7;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned InTdataW    = 48;
  localparam int unsigned OutTdataW   = 48;

endpackage

// ===== rtl/positional_stack_engine.sv =====
// top level of the positional stack engine
`timescale 1ns / 1ps

// Bounded LIFO stack of DEPTH words with positional access. Each input transfer
// is one operation and yields exactly one result transfer (status, word read
// or removed, new count). The words sit in a row of DEPTH cells that all
// update at once, each keeping its word, taking a neighbor's word (shift for
// insert or remove) or loading the new word; reverse flips an orientation flag
// instead of moving data. The result sits in an output register, so a new
// operation is accepted in the same cycle a waiting result is taken. No
// clearing pass follows reset.
module positional_stack_engine
  import pse_pkg::*;
#(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // op[2:0], value[34:3], position[41:35], zero fill above
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[1:0], word_out[33:2], count[40:34], zero fill above
  output logic [OutTdataW-1:0] m_axis_tdata
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > PosWidth) ? CW : PosWidth;

  // input fields
  op_e                   op;
  logic [WordWidth-1:0]  value;
  logic [PosWidth-1:0]   position;
  logic [DATA_WIDTH+WordWidth-1:0] value_ext;
  logic [DATA_WIDTH-1:0] value_w;

  assign op        = op_e'(s_axis_tdata[OpWidth-1:0]);
  assign value     = s_axis_tdata[OpWidth+WordWidth-1:OpWidth];
  assign position  = s_axis_tdata[OpWidth+WordWidth+PosWidth-1:OpWidth+WordWidth];
  assign value_ext = {{DATA_WIDTH{1'b0}}, value};
  assign value_w   = value_ext[DATA_WIDTH-1:0];

  // control state
  logic [CW-1:0] cnt_q, cnt_d;
  logic          dir_q, dir_d;
  logic          out_valid_q;
  status_e       out_status_q, status;
  logic [WordWidth-1:0]  out_word_q;
  logic [CountWidth-1:0] out_count_q;

  logic fire;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  // cell row wiring
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  cell_cmd_e             cell_cmd  [DEPTH];

  // index arithmetic, widened to cover both count and position
  logic [PW-1:0] pos_w, cnt_w, ins_pos, acc_pos, ins_k_w, acc_k_w;
  logic [IW-1:0] ins_k, acc_k;
  logic          is_full, is_empty;

  assign pos_w    = PW'(position);
  assign cnt_w    = PW'(cnt_q);
  assign is_full  = (cnt_w == PW'(DEPTH));
  assign is_empty = (cnt_q == '0);
  assign ins_pos  = (op == OP_PUSH) ? '0 : pos_w;
  assign acc_pos  = ((op == OP_PEEK) || (op == OP_POP)) ? PW'(1) : pos_w;
  // orientation 0 keeps the top in cell 0, orientation 1 keeps it in cell count-1
  assign ins_k_w  = dir_q ? (cnt_w - ins_pos) : ins_pos;
  assign acc_k_w  = dir_q ? (cnt_w - acc_pos) : (acc_pos - PW'(1));
  assign ins_k    = ins_k_w[IW-1:0];
  assign acc_k    = acc_k_w[IW-1:0];

  // read port over the row
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH+WordWidth-1:0] rd_ext;
  logic [WordWidth-1:0] word;
  assign rd_word = cell_data[acc_k];
  assign rd_ext  = {{WordWidth{1'b0}}, rd_word};

  // operation decode
  logic do_ins, do_rem;
  always_comb begin
    status = ST_OK;
    word   = '0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    dir_d  = dir_q;
    unique case (op) inside
      OP_PUSH: begin
        if (is_full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INSERT_AT: begin
        if (pos_w > cnt_w) status = ST_BADPOS;
        else if (is_full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_PEEK, OP_POP: begin
        if (is_empty) status = ST_EMPTY;
        else begin
          word   = rd_ext[WordWidth-1:0];
          do_rem = (op == OP_POP);
        end
      end
      OP_READ_AT, OP_REMOVE_AT: begin
        if (is_empty) status = ST_EMPTY;
        else if ((pos_w == '0) || (pos_w > cnt_w)) status = ST_BADPOS;
        else begin
          word   = rd_ext[WordWidth-1:0];
          do_rem = (op == OP_REMOVE_AT);
        end
      end
      OP_REVERSE: begin
        if (is_empty) status = ST_EMPTY;
        else dir_d = !dir_q;
      end
      default: ;
    endcase
  end

  // next count
  always_comb begin
    cnt_d = cnt_q;
    if (do_ins) cnt_d = cnt_q + CW'(1);
    else if (do_rem) cnt_d = cnt_q - CW'(1);
  end

  logic [CW+CountWidth-1:0] cnt_ext;
  assign cnt_ext = {{CountWidth{1'b0}}, cnt_d};

  // row of cells, each commanded from its own position
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_data[i+1];
    end

    always_comb begin
      cell_cmd[i] = CELL_HOLD;
      if (fire && do_ins) begin
        if (ins_k == IW'(i)) cell_cmd[i] = CELL_LOAD;
        else if (IW'(i) > ins_k) cell_cmd[i] = CELL_FROM_LOWER;
      end else if (fire && do_rem) begin
        if (IW'(i) >= acc_k) cell_cmd[i] = CELL_FROM_UPPER;
      end
    end

    pse_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cell_cmd[i]),
      .load_i (value_w),
      .lower_i(lower),
      .upper_i(upper),
      .data_o (cell_data[i])
    );
  end

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q       <= cnt_d;
        dir_q       <= dir_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= status;
      out_word_q   <= word;
      out_count_q  <= cnt_ext[CountWidth-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW-StatusWidth-WordWidth-CountWidth){1'b0}},
                          out_count_q, out_word_q, out_status_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("stack count above depth");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted operation left no result");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && do_ins) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow the stack");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (status == ST_FULL)) |-> (cnt_q == CW'(DEPTH)))
    else $error("full status on a stack that is not full");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (status == ST_EMPTY)) |-> (cnt_q == '0))
    else $error("empty status on a stack that holds words");
`endif

endmodule

// ===== rtl/pse_cell.sv =====
// one storage cell of the stack row
`timescale 1ns / 1ps

module pse_cell
  import pse_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_cmd_e             cmd_i,
  input  logic [DATA_WIDTH-1:0] load_i,
  input  logic [DATA_WIDTH-1:0] lower_i,
  input  logic [DATA_WIDTH-1:0] upper_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  // pick the next word: keep, take a neighbor, or load the new word
  always_comb begin
    case (cmd_i)
      CELL_FROM_LOWER: data_d = lower_i;
      CELL_FROM_UPPER: data_d = upper_i;
      CELL_LOAD:       data_d = load_i;
      default:         data_d = data_q;
    endcase
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the positional stack engine
`timescale 1ns / 1ps

module tb_top;
  import pse_pkg::*;

  localparam int unsigned Depth       = 64;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned Timeout     = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [OpWidth-1:0] OpIgnored = 3'd7;

  // one operation, last field in the lowest bits
  typedef struct packed {
    logic [PosWidth-1:0]  position;
    logic [WordWidth-1:0] value;
    logic [OpWidth-1:0]   op;
  } op_item_t;

  // one result, last field in the lowest bits
  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic [WordWidth-1:0]  word_out;
    status_e               status;
  } stack_result_t;

  // directed stimulus row; known rows carry their typed result
  typedef struct {
    logic [OpWidth-1:0]    op;
    logic [WordWidth-1:0]  value;
    logic [PosWidth-1:0]   position;
    bit                    known;
    status_e               status;
    logic [WordWidth-1:0]  word_out;
    logic [CountWidth-1:0] count;
  } dir_row_t;

  dir_row_t dir_table [27] = '{
    '{OP_PEEK,      32'h0,         7'd0,  1'b1, ST_EMPTY,  32'h0,         7'd0},
    '{OP_POP,       32'h0,         7'd0,  1'b1, ST_EMPTY,  32'h0,         7'd0},
    '{OP_READ_AT,   32'h0,         7'd1,  1'b1, ST_EMPTY,  32'h0,         7'd0},
    '{OP_REMOVE_AT, 32'h0,         7'd1,  1'b1, ST_EMPTY,  32'h0,         7'd0},
    '{OP_REVERSE,   32'h0,         7'd0,  1'b1, ST_EMPTY,  32'h0,         7'd0},
    '{OP_INSERT_AT, 32'hdead_beef, 7'd1,  1'b1, ST_BADPOS, 32'h0,         7'd0},
    '{OP_READ_AT,   32'h0,         7'd0,  1'b1, ST_EMPTY,  32'h0,         7'd0},
    '{OpIgnored,    32'hffff_ffff, 7'd64, 1'b1, ST_OK,     32'h0,         7'd0},
    '{OP_PUSH,      32'hffff_ffff, 7'd0,  1'b1, ST_OK,     32'h0,         7'd1},
    '{OP_REVERSE,   32'h0,         7'd0,  1'b1, ST_OK,     32'h0,         7'd1},
    '{OP_PEEK,      32'h0,         7'd0,  1'b1, ST_OK,     32'hffff_ffff, 7'd1},
    '{OP_READ_AT,   32'h0,         7'd0,  1'b1, ST_BADPOS, 32'h0,         7'd1},
    '{OP_READ_AT,   32'h0,         7'd2,  1'b1, ST_BADPOS, 32'h0,         7'd1},
    '{OP_REMOVE_AT, 32'h0,         7'd64, 1'b1, ST_BADPOS, 32'h0,         7'd1},
    '{OP_INSERT_AT, 32'hffff_ffff, 7'd64, 1'b1, ST_BADPOS, 32'h0,         7'd1},
    '{OP_INSERT_AT, 32'h0,         7'd1,  1'b1, ST_OK,     32'h0,         7'd2},
    '{OP_INSERT_AT, 32'h5a5a_5a5a, 7'd0,  1'b1, ST_OK,     32'h0,         7'd3},
    '{OP_INSERT_AT, 32'h0000_0001, 7'd2,  1'b0, ST_OK,     32'h0,         7'd0},
    '{OP_READ_AT,   32'h0,         7'd4,  1'b0, ST_OK,     32'h0,         7'd0},
    '{OP_REVERSE,   32'h0,         7'd0,  1'b0, ST_OK,     32'h0,         7'd0},
    '{OP_REMOVE_AT, 32'h0,         7'd2,  1'b0, ST_OK,     32'h0,         7'd0},
    '{OP_READ_AT,   32'h0,         7'd3,  1'b0, ST_OK,     32'h0,         7'd0},
    '{OpIgnored,    32'hffff_ffff, 7'd64, 1'b1, ST_OK,     32'h0,         7'd3},
    '{OP_POP,       32'h0,         7'd0,  1'b0, ST_OK,     32'h0,         7'd0},
    '{OP_REMOVE_AT, 32'h0,         7'd1,  1'b0, ST_OK,     32'h0,         7'd0},
    '{OP_POP,       32'h0,         7'd0,  1'b0, ST_OK,     32'h0,         7'd0},
    '{OP_POP,       32'h0,         7'd0,  1'b1, ST_EMPTY,  32'h0,         7'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InTdataW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  // operation currently offered, with its typed result where known
  op_item_t      in_item = '0;
  bit            in_known = 1'b0;
  stack_result_t in_want = '0;

  // predicted stack contents, slot 0 at the bottom
  logic [WordWidth-1:0] stack_words [Depth];
  int unsigned          stack_fill = 0;
  stack_result_t        pending_results [$];

  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_hits = 0;
  int unsigned badpos_hits = 0;
  int unsigned empty_hits = 0;
  int unsigned deepest = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;

  assign s_axis_tdata = InTdataW'(in_item);

  positional_stack_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // apply one operation to the predicted stack and return its result
  function automatic stack_result_t apply_op(op_item_t item);
    stack_result_t res;
    int unsigned slot;
    int unsigned pos;
    logic [WordWidth-1:0] tmp;
    res.status = ST_OK;
    res.word_out = '0;
    pos = 32'(item.position);
    case (item.op) inside
      OP_PUSH: begin
        if (stack_fill >= Depth) begin
          res.status = ST_FULL;
        end else begin
          stack_words[stack_fill] = item.value;
          stack_fill++;
        end
      end
      OP_INSERT_AT: begin
        // position check comes before the full check
        if (pos > stack_fill) begin
          res.status = ST_BADPOS;
        end else if (stack_fill >= Depth) begin
          res.status = ST_FULL;
        end else begin
          slot = stack_fill - pos;
          for (int i = stack_fill; i > slot; i--) stack_words[i] = stack_words[i-1];
          stack_words[slot] = item.value;
          stack_fill++;
        end
      end
      OP_PEEK, OP_POP: begin
        if (stack_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.word_out = stack_words[stack_fill-1];
          if (item.op == OP_POP) stack_fill--;
        end
      end
      OP_READ_AT, OP_REMOVE_AT: begin
        if (stack_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (pos == 0 || pos > stack_fill) begin
          res.status = ST_BADPOS;
        end else begin
          slot = stack_fill - pos;
          res.word_out = stack_words[slot];
          if (item.op == OP_REMOVE_AT) begin
            for (int i = slot; i + 1 < stack_fill; i++) stack_words[i] = stack_words[i+1];
            stack_fill--;
          end
        end
      end
      OP_REVERSE: begin
        if (stack_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < stack_fill / 2; i++) begin
            tmp = stack_words[i];
            stack_words[i] = stack_words[stack_fill-1-i];
            stack_words[stack_fill-1-i] = tmp;
          end
        end
      end
      default: ;
    endcase
    res.count = CountWidth'(stack_fill);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WordWidth-1:0] got,
                                 logic [WordWidth-1:0] want);
    $display("mismatch on result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
    err_count++;
  endtask

  // compare result transfers and predict accepted operations
  always @(posedge clk_i) begin
    stack_result_t got, want, pred;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(stack_result_t)-1:0];
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, word", got.word_out, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            report_mismatch("status", WordWidth'(got.status), WordWidth'(want.status));
          end
          if (got.word_out !== want.word_out) report_mismatch("word", got.word_out, want.word_out);
          if (got.count !== want.count) begin
            report_mismatch("count", WordWidth'(got.count), WordWidth'(want.count));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = apply_op(in_item);
        pending_results.push_back(in_known ? in_want : pred);
        items_sent++;
        if (pred.status == ST_FULL) full_hits++;
        if (pred.status == ST_BADPOS) badpos_hits++;
        if (pred.status == ST_EMPTY) empty_hits++;
        if (stack_fill > deepest) deepest = stack_fill;
      end
    end
  end

  // stop the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= Timeout) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("[positional_stack_engine] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // offer one operation; entered and left at a falling edge
  task automatic send_op(input logic [OpWidth-1:0] op, input logic [WordWidth-1:0] value,
                         input logic [PosWidth-1:0] position, input bit known = 1'b0,
                         input stack_result_t want = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    in_item <= '{position: position, value: value, op: op};
    in_known <= known;
    in_want <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop offering until every pending result has arrived
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // one operation steering the fill toward target; noisy picks anything
  task automatic random_op(int unsigned target, bit noisy);
    int unsigned r;
    int unsigned fill;
    bit grow;
    bit sane;
    logic [OpWidth-1:0] op;
    logic [PosWidth-1:0] pos;
    fill = stack_fill;
    grow = fill < target;
    r = $urandom_range(0, 99);
    sane = !noisy && ($urandom_range(0, 9) != 0);
    if (noisy) op = OpWidth'($urandom_range(0, 7));
    else if (r < 2) op = OpIgnored;
    else if (r < 50) op = grow ? ($urandom_range(0, 1) ? OP_PUSH : OP_INSERT_AT)
                               : ($urandom_range(0, 1) ? OP_POP : OP_REMOVE_AT);
    else if (r < 62) op = grow ? ($urandom_range(0, 1) ? OP_POP : OP_REMOVE_AT)
                               : ($urandom_range(0, 1) ? OP_PUSH : OP_INSERT_AT);
    else if (r < 72) op = OP_PEEK;
    else if (r < 92) op = OP_READ_AT;
    else op = OP_REVERSE;
    if (!sane) pos = PosWidth'($urandom_range(0, Depth));
    else if (op == OP_INSERT_AT) pos = PosWidth'($urandom_range(0, fill));
    else if (fill == 0) pos = 7'd1;
    else pos = PosWidth'($urandom_range(1, fill));
    send_op(op, $urandom(), pos);
  endtask

  // fill to the top, hit the full cases, then empty it again and hit the empty cases
  task automatic fill_and_drain();
    while (stack_fill < Depth) begin
      if ($urandom_range(0, 3) != 0) send_op(OP_PUSH, $urandom(), '0);
      else send_op(OP_INSERT_AT, $urandom(), PosWidth'($urandom_range(0, stack_fill)));
    end
    send_op(OP_PUSH, $urandom(), '0);
    send_op(OP_INSERT_AT, $urandom(), PosWidth'($urandom_range(0, Depth)));
    send_op(OP_REVERSE, $urandom(), '0);
    send_op(OP_READ_AT, $urandom(), PosWidth'(Depth));
    send_op(OP_READ_AT, $urandom(), 7'd1);
    send_op(OP_REMOVE_AT, $urandom(), PosWidth'(Depth));
    while (stack_fill > 0) begin
      if ($urandom_range(0, 1) != 0) send_op(OP_POP, $urandom(), '0);
      else send_op(OP_REMOVE_AT, $urandom(), PosWidth'($urandom_range(1, stack_fill)));
    end
    send_op(OP_POP, $urandom(), '0);
    send_op(OP_PEEK, $urandom(), '0);
  endtask

  // main sequence
  initial begin
    int unsigned rand_start;
    int unsigned done_items;
    int unsigned kind;
    bit pressed;
    pressed = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 56;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_table[i]) begin
      send_op(dir_table[i].op, dir_table[i].value, dir_table[i].position, dir_table[i].known,
              '{count: dir_table[i].count, word_out: dir_table[i].word_out,
                status: dir_table[i].status});
    end

    // random part in three idling phases
    rand_start = items_sent;
    while (items_sent < rand_start + RandomItems) begin
      done_items = items_sent - rand_start;
      if (done_items >= 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (!pressed) begin
          // long hold-off on the result side while operations keep coming
          hold_req = 1'b1;
          repeat (8) random_op(Depth / 2, 1'b0);
          wait_for_results();
          pressed = 1'b1;
        end
      end else if (done_items >= RandomItems / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 15;
      end
      kind = $urandom_range(0, 9);
      if (kind < 2) fill_and_drain();
      else if (kind < 9) begin
        done_items = $urandom_range(0, Depth);
        repeat ($urandom_range(20, 40)) random_op(done_items, 1'b0);
      end else begin
        repeat ($urandom_range(5, 10)) random_op(0, 1'b1);
      end
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never arrived, count", pending_results.size(), '0);
    end

    $display("ran %0d operations, checked %0d results, deepest fill %0d",
             items_sent, results_seen, deepest);
    $display("full status %0d times, bad position %0d times, empty %0d times",
             full_hits, badpos_hits, empty_hits);
    if (err_count == 0) begin
      $display("[positional_stack_engine] OK");
    end else begin
      $display("[positional_stack_engine] ERROR");
    end
    $finish;
  end

endmodule
